/* design/bftm_pkg.sv */
// Package for the tape machine executor: constants, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bftm_pkg;
    localparam int PROG_DEPTH = 1024;
    localparam int TAPE_DEPTH = 32768;
    localparam int NEST_DEPTH = 64;
    localparam int MAX_RUN    = 16;
    localparam int BURST_MAX  = 16;
    localparam int RUN_LIMIT  = (MAX_RUN < BURST_MAX) ? MAX_RUN : BURST_MAX;

    localparam int PA_W  = $clog2(PROG_DEPTH);
    localparam int PC_W  = PA_W + 1;
    localparam int TP_W  = $clog2(TAPE_DEPTH);
    localparam int SA_W  = $clog2(NEST_DEPTH);
    localparam int SD_W  = SA_W + 1;

    typedef enum logic [1:0] {
        OPER_LOAD   = 2'd0,
        OPER_STEP   = 2'd1,
        OPER_SUPPLY = 2'd2,
        OPER_BAD    = 2'd3
    } oper_t;

    typedef enum logic [2:0] {
        OP_RIGHT = 3'd0, OP_LEFT = 3'd1, OP_INC = 3'd2, OP_DEC = 3'd3,
        OP_OUT = 3'd4, OP_IN = 3'd5, OP_OPEN = 3'd6, OP_CLOSE = 3'd7
    } op_kind_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_HALT = 3'd1, ST_WAIT = 3'd2, ST_BRACKET = 3'd3,
        ST_FULL = 3'd4, ST_REJECT = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_EMIT, S_RESULT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic clear_en;     // write zero to tape at clear address
        logic latch;        // capture input item, start reads
        logic exec;         // apply the item using read data
        logic emit_adv;     // one output repeat taken
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic is_emit;      // item produces a burst
        logic emit_last;    // current burst entry is the final one
    } sts_t;
endpackage
`default_nettype wire

/* design/bftm_ctrl.sv */
// Controller state machine for the tape machine executor.
// Depends on bftm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bftm_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_fire,
    input  wire logic         out_fire,
    input  wire bftm_pkg::sts_t sts,
    output bftm_pkg::cmd_t    cmd,
    output logic              in_ready,
    output logic              out_busy
);
    bftm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bftm_pkg::S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bftm_pkg::S_CLEAR:  if (sts.clear_done) state_next = bftm_pkg::S_IDLE;
            bftm_pkg::S_IDLE:   if (in_fire) state_next = bftm_pkg::S_EXEC;
            bftm_pkg::S_EXEC:   state_next = sts.is_emit ? bftm_pkg::S_EMIT
                                                         : bftm_pkg::S_RESULT;
            bftm_pkg::S_EMIT:   if (out_fire && sts.emit_last) state_next = bftm_pkg::S_IDLE;
            bftm_pkg::S_RESULT: if (out_fire) state_next = bftm_pkg::S_IDLE;
            default:            state_next = bftm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        out_busy = 1'b0;
        case (state_reg)
            bftm_pkg::S_CLEAR:  cmd.clear_en = 1'b1;
            bftm_pkg::S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_fire;
            end
            bftm_pkg::S_EXEC:   cmd.exec = 1'b1;
            bftm_pkg::S_EMIT:
            begin
                out_busy     = 1'b1;
                cmd.emit_adv = out_fire;
            end
            bftm_pkg::S_RESULT: out_busy = 1'b1;
            default:            cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

/* design/bftm_dp.sv */
// Datapath: program store, jump table, bracket stack, tape and machine registers.
// Depends on bftm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bftm_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bftm_pkg::cmd_t cmd,
    input  wire logic [1:0]     operation,
    input  wire logic [2:0]     op_kind,
    input  wire logic [4:0]     op_count,
    input  wire logic [7:0]     in_byte,
    output bftm_pkg::sts_t      sts,
    output logic [2:0]          status,
    output logic                out_valid,
    output logic [7:0]          out_byte,
    output logic                last,
    output logic [10:0]         program_counter,
    output logic [14:0]         data_pointer
);
    localparam int PA_W = bftm_pkg::PA_W;
    localparam int PC_W = bftm_pkg::PC_W;
    localparam int TP_W = bftm_pkg::TP_W;
    localparam int SA_W = bftm_pkg::SA_W;
    localparam int SD_W = bftm_pkg::SD_W;

    logic [7:0]      prog_mem [bftm_pkg::PROG_DEPTH];
    logic [PA_W-1:0] jump_mem [bftm_pkg::PROG_DEPTH];
    logic [PA_W-1:0] stack_mem [bftm_pkg::NEST_DEPTH];
    logic [7:0]      tape_mem [bftm_pkg::TAPE_DEPTH];

    logic [SD_W-1:0] depth_reg;
    logic [PC_W-1:0] len_reg, pc_reg;
    logic [TP_W-1:0] tp_reg;
    logic [4:0]      pend_reg;
    logic            err_reg;
    logic [TP_W:0]   clr_reg;

    logic [1:0]      oper_reg;
    logic [2:0]      kind_reg;
    logic [4:0]      cnt_reg;
    logic [7:0]      byte_reg;

    logic [7:0]      prog_rd, cell_rd;
    logic [PA_W-1:0] jump_rd, stack_rd;

    logic [2:0]      status_reg;
    logic [7:0]      obyte_reg;
    logic            ovalid_reg;
    logic [4:0]      emit_reg;

    // synchronous reads at latch time
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            prog_rd  <= prog_mem[pc_reg[PA_W-1:0]];
            jump_rd  <= jump_mem[pc_reg[PA_W-1:0]];
            cell_rd  <= tape_mem[tp_reg];
            stack_rd <= stack_mem[SA_W'(depth_reg - SD_W'(1))];
            oper_reg <= operation;
            kind_reg <= op_kind;
            cnt_reg  <= op_count;
            byte_reg <= in_byte;
        end
    end

    // execute decode
    logic [2:0]      st;
    logic            ld_store, ld_push, ld_pop, set_err;
    logic            tape_we, pend_we;
    logic [7:0]      tape_wd;
    logic [4:0]      pend_wd;
    logic [PC_W-1:0] pc_nx;
    logic [TP_W-1:0] tp_nx;
    logic            emit;
    logic [2:0]      xk;
    logic [4:0]      xn;
    logic [4:0]      burst;

    always_comb
    begin
        st = bftm_pkg::ST_OK;
        ld_store = 1'b0; ld_push = 1'b0; ld_pop = 1'b0; set_err = 1'b0;
        tape_we = 1'b0; tape_wd = byte_reg; pend_we = 1'b0; pend_wd = '0;
        pc_nx = pc_reg; tp_nx = tp_reg; emit = 1'b0;
        xk = prog_rd[2:0]; xn = prog_rd[7:3];
        burst = (xn > 5'(bftm_pkg::BURST_MAX)) ? 5'(bftm_pkg::BURST_MAX) : xn;
        case (oper_reg)
            bftm_pkg::OPER_LOAD:
            begin
                if (err_reg)
                    st = bftm_pkg::ST_BRACKET;
                else if (kind_reg < 3'(bftm_pkg::OP_OPEN) &&
                         (cnt_reg == 5'd0 || cnt_reg > 5'(bftm_pkg::RUN_LIMIT)))
                    st = bftm_pkg::ST_REJECT;
                else if (len_reg >= PC_W'(bftm_pkg::PROG_DEPTH))
                    st = bftm_pkg::ST_FULL;
                else if (kind_reg == bftm_pkg::OP_OPEN)
                begin
                    if (depth_reg >= SD_W'(bftm_pkg::NEST_DEPTH))
                    begin
                        set_err = 1'b1; st = bftm_pkg::ST_BRACKET;
                    end
                    else
                    begin
                        ld_push = 1'b1; ld_store = 1'b1;
                    end
                end
                else if (kind_reg == bftm_pkg::OP_CLOSE)
                begin
                    if (depth_reg == '0)
                    begin
                        set_err = 1'b1; st = bftm_pkg::ST_BRACKET;
                    end
                    else
                    begin
                        ld_pop = 1'b1; ld_store = 1'b1;
                    end
                end
                else
                    ld_store = 1'b1;
            end
            bftm_pkg::OPER_SUPPLY:
            begin
                if (pend_reg == '0)
                    st = bftm_pkg::ST_REJECT;
                else
                begin
                    tape_we = 1'b1;
                    pend_we = 1'b1;
                    pend_wd = pend_reg - 5'd1;
                    st = (pend_reg != 5'd1) ? bftm_pkg::ST_WAIT : bftm_pkg::ST_OK;
                end
            end
            bftm_pkg::OPER_STEP:
            begin
                if (err_reg || depth_reg != '0)
                    st = bftm_pkg::ST_BRACKET;
                else if (pend_reg != '0)
                    st = bftm_pkg::ST_WAIT;
                else if (pc_reg >= len_reg)
                    st = bftm_pkg::ST_HALT;
                else
                begin
                    pc_nx = pc_reg + PC_W'(1);
                    case (xk)
                        bftm_pkg::OP_RIGHT: tp_nx = tp_reg + TP_W'(xn);
                        bftm_pkg::OP_LEFT:  tp_nx = tp_reg - TP_W'(xn);
                        bftm_pkg::OP_INC:
                        begin
                            tape_we = 1'b1; tape_wd = cell_rd + 8'(xn);
                        end
                        bftm_pkg::OP_DEC:
                        begin
                            tape_we = 1'b1; tape_wd = cell_rd - 8'(xn);
                        end
                        bftm_pkg::OP_OUT:   emit = (burst != 5'd0);
                        bftm_pkg::OP_IN:
                        begin
                            pend_we = 1'b1; pend_wd = xn;
                            if (xn != 5'd0) st = bftm_pkg::ST_WAIT;
                        end
                        bftm_pkg::OP_OPEN:
                            if (cell_rd == 8'd0) pc_nx = PC_W'(jump_rd) + PC_W'(1);
                        default:
                            if (cell_rd != 8'd0) pc_nx = PC_W'(jump_rd) + PC_W'(1);
                    endcase
                end
            end
            default: st = bftm_pkg::ST_REJECT;
        endcase
    end

    // memory writes
    always_ff @(posedge clk)
    begin
        if (cmd.exec && ld_store)
            prog_mem[len_reg[PA_W-1:0]] <= (kind_reg >= 3'(bftm_pkg::OP_OPEN))
                                           ? {5'd0, kind_reg} : {cnt_reg, kind_reg};
        if (cmd.exec && ld_push)
            stack_mem[depth_reg[SA_W-1:0]] <= len_reg[PA_W-1:0];
    end

    // close writes its own entry now and the opener's entry on the next cycle
    logic            jfix_reg;
    logic [PA_W-1:0] jfix_a_reg, jfix_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            jfix_reg <= 1'b0;
        else
            jfix_reg <= cmd.exec && ld_pop;
    end
    always_ff @(posedge clk)
    begin
        jfix_a_reg <= stack_rd;
        jfix_d_reg <= len_reg[PA_W-1:0];
        if (cmd.exec && ld_pop)
            jump_mem[len_reg[PA_W-1:0]] <= stack_rd;
        else if (jfix_reg)
            jump_mem[jfix_a_reg] <= jfix_d_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
            tape_mem[clr_reg[TP_W-1:0]] <= 8'd0;
        else if (cmd.exec && tape_we)
            tape_mem[tp_reg] <= tape_wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= '0; len_reg <= '0; pc_reg <= '0; tp_reg <= '0;
            pend_reg   <= '0; err_reg <= 1'b0; clr_reg <= '0;
            status_reg <= '0; ovalid_reg <= 1'b0; emit_reg <= '0;
        end
        else
        begin
            if (cmd.clear_en && !clr_reg[TP_W])
                clr_reg <= clr_reg + (TP_W+1)'(1);
            if (cmd.exec)
            begin
                if (ld_store) len_reg <= len_reg + PC_W'(1);
                if (ld_push)  depth_reg <= depth_reg + SD_W'(1);
                if (ld_pop)   depth_reg <= depth_reg - SD_W'(1);
                if (set_err)  err_reg <= 1'b1;
                if (pend_we)  pend_reg <= pend_wd;
                pc_reg     <= pc_nx;
                tp_reg     <= tp_nx;
                status_reg <= st;
                ovalid_reg <= emit;
                emit_reg   <= burst - 5'd1;
            end
            else if (cmd.emit_adv)
                emit_reg <= emit_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
            obyte_reg <= emit ? cell_rd : 8'd0;
    end

    // is_emit is sampled in the execute cycle, emit_last in the burst
    assign sts.clear_done = clr_reg[TP_W];
    assign sts.is_emit    = emit;
    assign sts.emit_last  = (emit_reg == 5'd0);

    assign status          = status_reg;
    assign out_valid       = ovalid_reg;
    assign out_byte        = obyte_reg;
    assign last            = !ovalid_reg || (emit_reg == 5'd0);
    assign program_counter = pc_reg;
    assign data_pointer    = tp_reg;
endmodule
`default_nettype wire

/* design/bf_tape_machine_executor_top.sv */
// Top level of the tape machine executor: controller plus datapath.
// Depends on bftm_pkg, bftm_ctrl, bftm_dp.
//
//  channel | dir | tdata fields (low bit first)                         | tuser
//  s_axis  | in  | operation[1:0] op_kind[4:2] op_count[9:5] in_byte[17:10] | -
//  m_axis  | out | status[2:0] out_valid[3] out_byte[11:4] pc[22:12] dp[37:23] | tlast=last
//
// An item is read (program, jump table and tape), then applied, and then its results are
// handed over one by one before the next item is taken; an output op yields up to 16 results.
// After reset the tape is zeroed one entry a cycle, with s_axis_tready low until it is done.
// Either side may stall at any time; the result register holds until taken.
`timescale 1ns / 1ps
`default_nettype none
module bf_tape_machine_executor_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // operation, op_kind, op_count, in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // status, out_valid, out_byte, program_counter, data_pointer
    output logic             m_axis_tlast
);
    bftm_pkg::cmd_t cmd;
    bftm_pkg::sts_t sts;
    logic in_fire, out_fire;
    logic [2:0] status;
    logic ov;
    logic [7:0] ob;
    logic [10:0] pc;
    logic [14:0] dp;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    bftm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .sts(sts), .cmd(cmd), .in_ready(s_axis_tready), .out_busy(m_axis_tvalid)
    );

    bftm_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .operation(s_axis_tdata[1:0]), .op_kind(s_axis_tdata[4:2]),
        .op_count(s_axis_tdata[9:5]), .in_byte(s_axis_tdata[17:10]),
        .sts(sts), .status(status), .out_valid(ov), .out_byte(ob),
        .last(m_axis_tlast), .program_counter(pc), .data_pointer(dp)
    );

    assign m_axis_tdata = {2'b00, dp, pc, ob, ov, status};
endmodule
`default_nettype wire

/* design/bftm_checker.sv */
// Port-level checker for the tape machine executor, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none
module bftm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    // no new item while a result is pending
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept during output");
    // an accepted item is worked on before the next is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready straight after accept");
    // a non-emitting result is always last
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[3]) |-> m_axis_tlast) else $error("lone not last");
    // emitted bytes carry status ok
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[3]) |-> (m_axis_tdata[2:0] == 3'd0))
        else $error("emit status");
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");
endmodule

bind bf_tape_machine_executor_top bftm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

/* tb/tb.sv */
// Self-checking bench for bf_tape_machine_executor_top: loads counted ops, steps them,
// supplies bytes and checks every result item against an in-bench machine model.
// Depends on bftm_pkg and the design top level.
`timescale 1ns / 1ps
module tb;
    localparam int IDLE_LIMIT = 150000;  // several times the tape clear pass after reset
    localparam int TARGET     = 260;

    typedef struct {
        logic [2:0]  status;
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        last;
        logic [10:0] pc;
        logic [14:0] dp;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    bf_tape_machine_executor_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #10 clk = ~clk;

    // machine model state
    logic [2:0] prog_kind [bftm_pkg::PROG_DEPTH];
    logic [4:0] prog_count [bftm_pkg::PROG_DEPTH];
    int         partner [bftm_pkg::PROG_DEPTH];
    int         open_stack [bftm_pkg::NEST_DEPTH];
    logic [7:0] tape_cells [bftm_pkg::TAPE_DEPTH];
    int         depth, prog_len, pc_m, ptr_m, pending;
    bit         bracket_err;

    result_t    expected_results [$];
    int         mismatches;
    int         items_sent;
    bit         no_idle;
    bit         long_hold;

    function automatic void push_result(logic [2:0] st, logic v, logic [7:0] b, logic l);
        result_t r;
        r.status = st; r.out_valid = v; r.out_byte = b; r.last = l;
        r.pc = pc_m[10:0]; r.dp = ptr_m[14:0];
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic logic [2:0] load_op(logic [2:0] kind, logic [4:0] cnt);
        if (bracket_err)
            return bftm_pkg::ST_BRACKET;
        if (kind < bftm_pkg::OP_OPEN && (cnt == 0 || cnt > bftm_pkg::RUN_LIMIT))
            return bftm_pkg::ST_REJECT;
        if (prog_len >= bftm_pkg::PROG_DEPTH)
            return bftm_pkg::ST_FULL;
        if (kind == bftm_pkg::OP_OPEN)
        begin
            if (depth >= bftm_pkg::NEST_DEPTH)
            begin
                bracket_err = 1;
                return bftm_pkg::ST_BRACKET;
            end
            open_stack[depth] = prog_len;
            depth++;
            cnt = 0;
        end
        else if (kind == bftm_pkg::OP_CLOSE)
        begin
            if (depth == 0)
            begin
                bracket_err = 1;
                return bftm_pkg::ST_BRACKET;
            end
            depth--;
            partner[prog_len] = open_stack[depth];
            partner[open_stack[depth]] = prog_len;
            cnt = 0;
        end
        prog_kind[prog_len] = kind;
        prog_count[prog_len] = cnt;
        prog_len++;
        return bftm_pkg::ST_OK;
    endfunction

    task automatic predict_item(bftm_pkg::oper_t op, logic [2:0] kind, logic [4:0] cnt,
                                logic [7:0] data);
        logic [2:0] st;
        logic [7:0] cell_val;
        int n, next;
        st = bftm_pkg::ST_OK;
        case (op)
            bftm_pkg::OPER_LOAD: st = load_op(kind, cnt);
            bftm_pkg::OPER_SUPPLY:
                if (pending == 0)
                    st = bftm_pkg::ST_REJECT;
                else
                begin
                    tape_cells[ptr_m] = data;
                    pending--;
                    st = (pending != 0) ? bftm_pkg::ST_WAIT : bftm_pkg::ST_OK;
                end
            bftm_pkg::OPER_STEP:
                if (bracket_err || depth != 0)
                    st = bftm_pkg::ST_BRACKET;
                else if (pending != 0)
                    st = bftm_pkg::ST_WAIT;
                else if (pc_m >= prog_len)
                    st = bftm_pkg::ST_HALT;
                else
                begin
                    n = prog_count[pc_m];
                    cell_val = tape_cells[ptr_m];
                    next = pc_m + 1;
                    case (bftm_pkg::op_kind_t'(prog_kind[pc_m]))
                        bftm_pkg::OP_RIGHT: ptr_m = (ptr_m + n) % bftm_pkg::TAPE_DEPTH;
                        bftm_pkg::OP_LEFT:
                            ptr_m = (ptr_m + bftm_pkg::TAPE_DEPTH - n) % bftm_pkg::TAPE_DEPTH;
                        bftm_pkg::OP_INC:   tape_cells[ptr_m] = cell_val + n[7:0];
                        bftm_pkg::OP_DEC:   tape_cells[ptr_m] = cell_val - n[7:0];
                        bftm_pkg::OP_OUT:
                        begin
                            pc_m = next;
                            for (int i = 0; i < n; i++)
                                push_result(bftm_pkg::ST_OK, 1'b1, cell_val, i == n - 1);
                            return;
                        end
                        bftm_pkg::OP_IN:
                        begin
                            pending = n;
                            if (n != 0)
                                st = bftm_pkg::ST_WAIT;
                        end
                        bftm_pkg::OP_OPEN:  if (cell_val == 0) next = partner[pc_m] + 1;
                        default:            if (cell_val != 0) next = partner[pc_m] + 1;
                    endcase
                    pc_m = next;
                end
            default: st = bftm_pkg::ST_REJECT;
        endcase
        push_result(st, 1'b0, 8'h00, 1'b1);
    endtask

    task automatic send_item(bftm_pkg::oper_t op, logic [2:0] kind, logic [4:0] cnt,
                             logic [7:0] data);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, data, cnt, kind, op};
        do @(posedge clk); while (!s_axis_tready);
        predict_item(op, kind, cnt, data);
        items_sent++;
    endtask

    task automatic load(logic [2:0] kind, logic [4:0] cnt);
        send_item(bftm_pkg::OPER_LOAD, kind, cnt, 8'($urandom));
    endtask

    task automatic step_once();
        send_item(bftm_pkg::OPER_STEP, 3'($urandom), 5'($urandom), 8'($urandom));
    endtask

    task automatic supply(logic [7:0] data);
        send_item(bftm_pkg::OPER_SUPPLY, 3'($urandom), 5'($urandom), data);
    endtask

    // step until past the end, a bracket fault or max_steps, feeding bytes whenever input is due
    task automatic run_to_halt(int max_steps);
        int n;
        n = 0;
        while (!bracket_err && depth == 0 && pc_m < prog_len && n < max_steps)
        begin
            if (pending != 0)
                supply(8'($urandom));
            else
                step_once();
            n++;
        end
        if (pc_m >= prog_len)
            step_once();
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        step_once();                         // empty program: halted
        supply(8'hA5);                       // byte nobody asked for
        send_item(bftm_pkg::OPER_BAD, 3'd7, 5'd31, 8'hFF);
        load(bftm_pkg::OP_INC, 5'd0);        // zero count
        load(bftm_pkg::OP_INC, 5'd17);       // count above the run limit
        load(bftm_pkg::OP_DEC, 5'd31);
        load(bftm_pkg::OP_LEFT, 5'd1);       // wraps pointer below zero
        load(bftm_pkg::OP_RIGHT, 5'd16);
        load(bftm_pkg::OP_INC, 5'd16);
        load(bftm_pkg::OP_DEC, 5'd16);       // brings the cell back to zero
        load(bftm_pkg::OP_OUT, 5'd16);
        load(bftm_pkg::OP_IN, 5'd2);
        load(bftm_pkg::OP_OPEN, 5'd31);
        step_once();                         // unmatched open: refused
        load(bftm_pkg::OP_DEC, 5'd1);
        load(bftm_pkg::OP_CLOSE, 5'd0);
        load(bftm_pkg::OP_OUT, 5'd1);
        load(bftm_pkg::OP_OPEN, 5'd0);       // skipped on a zero cell
        load(bftm_pkg::OP_INC, 5'd1);
        load(bftm_pkg::OP_CLOSE, 5'd5);
        for (int i = 0; i < 6; i++)
            step_once();                     // last of these asks for input
        supply(8'hFF);
        supply(8'h03);
        run_to_halt(40);
        wait_drained();
    endtask

    task automatic test_random_programs();
        int open_now, len;
        while (items_sent < TARGET && prog_len < 900)
        begin
            if ($urandom_range(0, 9) == 0)
                no_idle = ~no_idle;
            open_now = 0;
            len = $urandom_range(2, 10);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 9))
                    0: send_item(bftm_pkg::OPER_BAD, 3'($urandom), 5'($urandom),
                                 8'($urandom));
                    1: load(3'($urandom_range(0, 5)),
                            $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31)));
                    2: step_once();
                    3: if (open_now < 3)
                    begin
                        load(bftm_pkg::OP_OPEN, 5'($urandom));
                        load(bftm_pkg::OP_DEC, 5'd1);
                        open_now++;
                    end
                    4: if (open_now > 0)
                    begin
                        load(bftm_pkg::OP_CLOSE, 5'($urandom));
                        open_now--;
                    end
                    default:
                        // keep loop bodies to decrement and output so loops end
                        if (open_now > 0)
                            load(bftm_pkg::OP_OUT, 5'($urandom_range(1, 16)));
                        else
                            load(3'($urandom_range(0, 5)), 5'($urandom_range(1, 16)));
                endcase
            end
            while (open_now > 0)
            begin
                load(bftm_pkg::OP_CLOSE, 5'($urandom));
                open_now--;
            end
            if ($urandom_range(0, 4) == 0)
                supply(8'($urandom));
            run_to_halt(60);
        end
        no_idle = 0;
        wait_drained();
    endtask

    task automatic test_backpressure();
        run_to_halt(20);
        for (int i = 0; i < 4; i++)
            load(bftm_pkg::OP_OUT, 5'd16);
        no_idle = 1;
        long_hold = 1;
        for (int i = 0; i < 8; i++)
            step_once();
        no_idle = 0;
        wait_drained();
    endtask

    task automatic test_close_without_open();
        load(bftm_pkg::OP_CLOSE, 5'd0);
        load(bftm_pkg::OP_INC, 5'd1);
        step_once();
        wait_drained();
    endtask

    // receiver: random stall per item, or one long hold on request
    initial
    begin
        int stall;
        forever
        begin
            if (long_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 0;
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 11);
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result item tdata=%h tlast=%b",
                             m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                e = expected_results.pop_front();
                if (m_axis_tdata[2:0] !== e.status || m_axis_tdata[3] !== e.out_valid ||
                    m_axis_tdata[11:4] !== e.out_byte || m_axis_tlast !== e.last ||
                    m_axis_tdata[22:12] !== e.pc || m_axis_tdata[37:23] !== e.dp)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: got st=%0d v=%b b=%h l=%b pc=%0d dp=%0d",
                                 m_axis_tdata[2:0], m_axis_tdata[3], m_axis_tdata[11:4],
                                 m_axis_tlast, m_axis_tdata[22:12], m_axis_tdata[37:23]);
                        $display("       exp st=%0d v=%b b=%h l=%b pc=%0d dp=%0d",
                                 e.status, e.out_valid, e.out_byte, e.last, e.pc, e.dp);
                    end
                end
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge clk)
    begin
        int quiet;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        foreach (tape_cells[i])
            tape_cells[i] = 8'h00;
        depth = 0; prog_len = 0; pc_m = 0; ptr_m = 0; pending = 0;
        bracket_err = 0; mismatches = 0; items_sent = 0; no_idle = 0; long_hold = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_programs();
        test_backpressure();
        test_close_without_open();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* sim.f */
design/bftm_pkg.sv
design/bftm_ctrl.sv
design/bftm_dp.sv
design/bf_tape_machine_executor_top.sv
design/bftm_checker.sv
tb/tb.sv
